/* sv/osm_pkg.sv */
// Shared constants, codes and types of the order-statistic multiset.
package osm_pkg;

  localparam int CAPACITY       = 256;
  localparam int KEY_BITS       = 31;
  localparam int RANK_BITS      = 8;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_OUT_BITS = 9;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (RANK_BITS > COUNT_W) ? RANK_BITS : COUNT_W;
  localparam int OUT_W   = (COUNT_OUT_BITS > COUNT_W) ? COUNT_OUT_BITS : COUNT_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT,
    S_READ
  } fsm_t;

  typedef struct packed {
    logic                cmp_en;
    logic                shift_en;
    logic                kind;
    logic [KEY_BITS-1:0] key;
    logic [COUNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

/* sv/osm_if.sv */
// Valid/ready channel interfaces for request and result words.
interface osm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [osm_pkg::KEY_BITS-1:0]  key;
  logic [osm_pkg::RANK_BITS-1:0] rank;

  modport source (output valid, kind, key, rank, input ready);
  modport sink   (input valid, kind, key, rank, output ready);
endinterface

interface osm_out_if;
  logic                               valid;
  logic                               ready;
  logic [osm_pkg::KEY_BITS-1:0]       value;
  logic                               rank_valid;
  logic [osm_pkg::STATUS_BITS-1:0]    update_status;
  logic [osm_pkg::COUNT_OUT_BITS-1:0] entry_count;

  modport source (output valid, value, rank_valid, update_status, entry_count, input ready);
  modport sink   (input valid, value, rank_valid, update_status, entry_count, output ready);
endinterface

/* sv/osm_cell.sv */
// One storage cell: holds a key, compares it with the request, shifts to/from neighbors.
module osm_cell (
  input  logic                         clk,
  input  osm_pkg::cell_ctrl_t          ctrl,
  input  logic                         valid,
  input  logic [osm_pkg::KEY_BITS-1:0] left_key,
  input  logic                         left_le,
  input  logic [osm_pkg::KEY_BITS-1:0] right_key,
  output logic [osm_pkg::KEY_BITS-1:0] key_o,
  output logic                         le_o,
  output logic                         eq_o
);

  logic [osm_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic lt_r, lt_nxt;
  logic le_r, le_nxt;
  logic eq_r, eq_nxt;

  always_comb begin
    lt_nxt  = lt_r;
    le_nxt  = le_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    if (ctrl.cmp_en) begin
      lt_nxt = valid && (key_r < ctrl.key);
      le_nxt = valid && (key_r <= ctrl.key);
      eq_nxt = valid && (key_r == ctrl.key);
    end
    if (ctrl.shift_en) begin
      if (ctrl.kind == osm_pkg::KIND_INSERT) begin
        if (!le_r) begin
          key_nxt = left_le ? ctrl.key : left_key;
        end
      end else begin
        if (!lt_r) begin
          key_nxt = right_key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    le_r  <= le_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_o = key_r;
  assign le_o  = le_r;
  assign eq_o  = eq_r;

endmodule

/* sv/osm_cell_row.sv */
// Row of storage cells in ascending key order, linked to both neighbors.
module osm_cell_row (
  input  logic                         clk,
  input  osm_pkg::cell_ctrl_t          ctrl,
  output logic [osm_pkg::KEY_BITS-1:0] keys [osm_pkg::CAPACITY],
  output logic [osm_pkg::CAPACITY-1:0] eq
);

  logic [osm_pkg::CAPACITY-1:0] le;

  for (genvar i = 0; i < osm_pkg::CAPACITY; i++) begin : g_cell
    logic                         valid;
    logic [osm_pkg::KEY_BITS-1:0] left_key;
    logic                         left_le;
    logic [osm_pkg::KEY_BITS-1:0] right_key;

    assign valid = osm_pkg::COUNT_W'(i) < ctrl.count;

    if (i == 0) begin : g_first
      assign left_key = ctrl.key;
      assign left_le  = 1'b1;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_le  = le[i-1];
    end

    if (i == osm_pkg::CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    osm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (valid),
      .left_key  (left_key),
      .left_le   (left_le),
      .right_key (right_key),
      .key_o     (keys[i]),
      .le_o      (le[i]),
      .eq_o      (eq[i])
    );
  end

endmodule

/* sv/order_statistic_multiset_unit.sv */
// Top level: sequencer, entry count, rank read and result register of the multiset.
//
// Usage:
//   in_ch  (sink)   : one request word per item: kind (insert/remove), key, rank.
//   out_ch (source) : one result word per item: value at rank, rank_valid,
//                     update_status and entry_count after the update.
// Each item runs through three steps: every cell compares its key with the
// request key in parallel, then the cells at and past the insertion/removal
// point shift one place toward or away from it together (not when an insert
// finds the store full or a remove finds no equal key), then the key at the
// requested rank is read from the row into the result register.
// A request is taken only while the sequencer is idle, so each item passes
// accept, compare, shift and read before the next one is accepted.
// The result register holds a word while the receiver stalls; the next
// request may be accepted meanwhile and waits in the read step until the
// register is freed.
// Reset (rst_n low, synchronous) empties the store, clears the result
// valid and holds in_ch.ready low; keys need no clearing since only
// entries below the count are ever read.
module order_statistic_multiset_unit (
  input logic   clk,
  input logic   rst_n,
  osm_in_if.sink    in_ch,
  osm_out_if.source out_ch
);

  osm_pkg::fsm_t state_r, state_nxt;

  logic                          kind_r, kind_nxt;
  logic [osm_pkg::KEY_BITS-1:0]  key_r, key_nxt;
  logic [osm_pkg::RANK_BITS-1:0] rank_r, rank_nxt;
  logic [osm_pkg::COUNT_W-1:0]   count_r, count_nxt;
  osm_pkg::status_t              status_r, status_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [osm_pkg::KEY_BITS-1:0]       out_value_r, out_value_nxt;
  logic                               out_rank_valid_r, out_rank_valid_nxt;
  osm_pkg::status_t                   out_status_r, out_status_nxt;
  logic [osm_pkg::COUNT_OUT_BITS-1:0] out_count_r, out_count_nxt;

  osm_pkg::cell_ctrl_t          ctrl;
  logic [osm_pkg::KEY_BITS-1:0] keys [osm_pkg::CAPACITY];
  logic [osm_pkg::CAPACITY-1:0] eq;

  logic                        found;
  logic                        full;
  logic [osm_pkg::CMP_W-1:0]   rank_ext;
  logic [osm_pkg::CMP_W-1:0]   count_ext;
  logic [osm_pkg::OUT_W-1:0]   count_out;
  logic                        rank_ok;

  assign found     = |eq;
  assign full      = count_r == osm_pkg::COUNT_W'(osm_pkg::CAPACITY);
  assign rank_ext  = osm_pkg::CMP_W'(rank_r);
  assign count_ext = osm_pkg::CMP_W'(count_r);
  assign count_out = osm_pkg::OUT_W'(count_r);
  assign rank_ok   = rank_ext < count_ext;

  assign in_ch.ready = rst_n && (state_r == osm_pkg::S_IDLE);

  always_comb begin
    state_nxt          = state_r;
    kind_nxt           = kind_r;
    key_nxt            = key_r;
    rank_nxt           = rank_r;
    count_nxt          = count_r;
    status_nxt         = status_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_value_nxt      = out_value_r;
    out_rank_valid_nxt = out_rank_valid_r;
    out_status_nxt     = out_status_r;
    out_count_nxt      = out_count_r;
    ctrl.cmp_en        = 1'b0;
    ctrl.shift_en      = 1'b0;
    ctrl.kind          = kind_r;
    ctrl.key           = key_r;
    ctrl.count         = count_r;
    case (state_r)
      osm_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          key_nxt   = in_ch.key;
          rank_nxt  = in_ch.rank;
          state_nxt = osm_pkg::S_CMP;
        end
      end
      osm_pkg::S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = osm_pkg::S_SHIFT;
      end
      osm_pkg::S_SHIFT: begin
        status_nxt = osm_pkg::ST_DONE;
        if (kind_r == osm_pkg::KIND_INSERT) begin
          if (full) begin
            status_nxt = osm_pkg::ST_FULL;
          end else begin
            ctrl.shift_en = 1'b1;
            count_nxt     = count_r + osm_pkg::COUNT_W'(1);
          end
        end else begin
          if (found) begin
            ctrl.shift_en = 1'b1;
            count_nxt     = count_r - osm_pkg::COUNT_W'(1);
          end else begin
            status_nxt = osm_pkg::ST_ABSENT;
          end
        end
        state_nxt = osm_pkg::S_READ;
      end
      osm_pkg::S_READ: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt      = 1'b1;
          out_value_nxt      = rank_ok ? keys[rank_ext[osm_pkg::IDX_W-1:0]] : '0;
          out_rank_valid_nxt = rank_ok;
          out_status_nxt     = status_r;
          out_count_nxt      = count_out[osm_pkg::COUNT_OUT_BITS-1:0];
          state_nxt          = osm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = osm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= osm_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r           <= kind_nxt;
    key_r            <= key_nxt;
    rank_r           <= rank_nxt;
    status_r         <= status_nxt;
    out_value_r      <= out_value_nxt;
    out_rank_valid_r <= out_rank_valid_nxt;
    out_status_r     <= out_status_nxt;
    out_count_r      <= out_count_nxt;
  end

  osm_cell_row u_row (
    .clk  (clk),
    .ctrl (ctrl),
    .keys (keys),
    .eq   (eq)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value         = out_value_r;
  assign out_ch.rank_valid    = out_rank_valid_r;
  assign out_ch.update_status = out_status_r;
  assign out_ch.entry_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= osm_pkg::COUNT_W'(osm_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == osm_pkg::S_SHIFT && kind_r == osm_pkg::KIND_INSERT && full)
    |=> $stable(count_r))
    else $error("dropped insert changed the count");

  a_absent_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == osm_pkg::S_SHIFT && kind_r == osm_pkg::KIND_REMOVE && !found)
    |=> $stable(count_r) && status_r == osm_pkg::ST_ABSENT)
    else $error("remove of absent key changed the count");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == osm_pkg::S_READ)
    else $error("result word raised outside the read step");

  a_rank_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rank_valid_r) |-> out_value_r == '0)
    else $error("invalid rank gave a nonzero value");

endmodule
